>>> sv/thp_pkg.sv
// Package with shared types, constants and register indexes for the sensor compensation.
`default_nettype none
package thp_pkg;

    localparam int RAW_T_W   = 20;
    localparam int RAW_P_W   = 20;
    localparam int RAW_H_W   = 16;
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 88;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int FIFO_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TRIM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_TRIM     = 3'd4;

    localparam logic [31:0] K_P_OFFSET   = 32'd64000;
    localparam logic [31:0] K_P_BASE     = 32'd1048576;
    localparam logic [31:0] K_P_SCALE    = 32'd3125;
    localparam logic [31:0] K_P_ONE      = 32'd32768;
    localparam logic [31:0] K_H_OFFSET   = 32'd76800;
    localparam logic [31:0] K_H_ROUND    = 32'd16384;
    localparam logic [31:0] K_H_ONE      = 32'd32768;
    localparam logic [31:0] K_H_BIAS     = 32'd2097152;
    localparam logic [31:0] K_H_ROUND2   = 32'd8192;
    localparam logic [31:0] K_H_MAX      = 32'd419430400;
    localparam logic [31:0] K_P_MAX      = 32'd1048575;

    // Trimming words as held in the configuration registers.
    typedef struct packed {
        logic [47:0] temp_trim;
        logic [63:0] press_trim_a;
        logic [63:0] press_trim_b;
        logic [15:0] press_trim_c;
        logic [63:0] hum_trim;
    } trim_t;

    // One raw measurement set.
    typedef struct packed {
        logic [RAW_H_W-1:0] raw_humidity;
        logic [RAW_P_W-1:0] raw_pressure;
        logic [RAW_T_W-1:0] raw_temperature;
    } raw_t;

    // One compensated result.
    typedef struct packed {
        logic [16:0] humidity_q22_10;
        logic        pressure_valid;
        logic [19:0] pressure_pa;
        logic [15:0] temperature_centi;
        logic [31:0] fine_temperature;
    } result_t;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE, S_T0, S_T1, S_T2,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6,
        S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7,
        S_WDIV, S_Q0, S_Q1, S_Q2, S_DONE
    } seq_state_t;

endpackage
`default_nettype wire

>>> sv/thp_front.sv
// Input side: accepts measurement beats into a short queue for the sequencer.
`default_nettype none
module thp_front #(
    parameter int DEPTH = thp_pkg::FIFO_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [thp_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                item_valid,
    output thp_pkg::raw_t                       item,
    input  wire logic                           item_pop
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    thp_pkg::raw_t     mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              push, pop;

    assign s_tready   = (count_reg != CW'(DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = mem_reg[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_pop && item_valid;

    // Pointer and fill-level arithmetic.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= thp_pkg::raw_t'(s_tdata);
        end
    end
endmodule
`default_nettype wire

>>> sv/thp_div.sv
// Iterative unsigned 32-bit divider, two quotient bits per cycle.
`default_nettype none
module thp_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire thp_pkg::div_req_t req,
    output thp_pkg::div_rsp_t      rsp
);
    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg, done_reg;

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    // Two restoring steps per cycle.
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < 2; i++)
        begin
            rem_next = {rem_next[31:0], quo_next[31]};
            quo_next = {quo_next[30:0], 1'b0};
            if (rem_next >= {1'b0, den_reg})
            begin
                rem_next    = rem_next - {1'b0, den_reg};
                quo_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == 4'hF)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end
endmodule
`default_nettype wire

>>> sv/thp_back.sv
// Compensation sequencer: one shared multiplier stepped through the integer formulas.
`default_nettype none
module thp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire thp_pkg::trim_t     trim,
    input  wire logic               item_valid,
    input  wire thp_pkg::raw_t      item,
    output logic                    item_pop,
    output thp_pkg::div_req_t       div_req,
    input  wire thp_pkg::div_rsp_t  div_rsp,
    output logic                    res_valid,
    output thp_pkg::result_t        res,
    input  wire logic               res_ready
);
    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    thp_pkg::seq_state_t state_reg, state_next;

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] adc_t_reg, adc_p_reg, adc_h_reg;
    logic [31:0] tv1_reg, rdd_reg, fine_reg, pv1_reg, q_reg, acc_reg, pv2_reg;
    logic [31:0] tmp_reg, den_reg, hv1_reg, hq_reg, ha_reg, hb_reg, hd_reg, hv_reg;
    logic [31:0] p_reg, pa_reg;
    logic        dbl_reg;
    logic [16:0] hum_reg;
    logic [19:0] pres_reg;
    logic        pvalid_reg;
    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] pv1, hv1, num, hfin, pfin;
    logic [34:0] tsum, tshift;
    logic [15:0] tcenti;
    logic        out_free;
    logic        res_valid_reg;
    thp_pkg::result_t res_reg;

    // Trim fields, widened to 32-bit words.
    assign t1 = {16'b0, trim.temp_trim[15:0]};
    assign t2 = sx(trim.temp_trim[31:16]);
    assign t3 = sx(trim.temp_trim[47:32]);
    assign p1 = {16'b0, trim.press_trim_a[15:0]};
    assign p2 = sx(trim.press_trim_a[31:16]);
    assign p3 = sx(trim.press_trim_a[47:32]);
    assign p4 = sx(trim.press_trim_a[63:48]);
    assign p5 = sx(trim.press_trim_b[15:0]);
    assign p6 = sx(trim.press_trim_b[31:16]);
    assign p7 = sx(trim.press_trim_b[47:32]);
    assign p8 = sx(trim.press_trim_b[63:48]);
    assign p9 = sx(trim.press_trim_c);
    assign h1 = {24'b0, trim.hum_trim[7:0]};
    assign h2 = sx(trim.hum_trim[23:8]);
    assign h3 = {24'b0, trim.hum_trim[31:24]};
    assign h4 = {{20{trim.hum_trim[43]}}, trim.hum_trim[43:32]};
    assign h5 = {{20{trim.hum_trim[55]}}, trim.hum_trim[55:44]};
    assign h6 = {{24{trim.hum_trim[63]}}, trim.hum_trim[63:56]};

    assign out_free  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Shared datapath terms.
    assign pv1  = asr(fine_reg, 1) - thp_pkg::K_P_OFFSET;
    assign hv1  = fine_reg - thp_pkg::K_H_OFFSET;
    assign prod = mul_a * mul_b;
    assign num  = prod;
    assign hfin = hv_reg - asr(prod, 4);
    assign pfin = p_reg + asr(pa_reg + asr(prod, 13) + p7, 4);

    // Temperature in hundredths: floor((fine * 5 + 128) / 256), saturated.
    assign tsum   = ({{3{fine_reg[31]}}, fine_reg} <<< 2) + {{3{fine_reg[31]}}, fine_reg}
                    + 35'd128;
    assign tshift = 35'($signed(tsum) >>> 8);
    always_comb
    begin
        if ($signed(tshift) > 35'sd32767)
        begin
            tcenti = 16'h7FFF;
        end
        else if ($signed(tshift) < -35'sd32768)
        begin
            tcenti = 16'h8000;
        end
        else
        begin
            tcenti = tshift[15:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            thp_pkg::S_IDLE: if (item_valid) state_next = thp_pkg::S_T0;
            thp_pkg::S_T0:   state_next = thp_pkg::S_T1;
            thp_pkg::S_T1:   state_next = thp_pkg::S_T2;
            thp_pkg::S_T2:   state_next = thp_pkg::S_P0;
            thp_pkg::S_P0:   state_next = thp_pkg::S_P1;
            thp_pkg::S_P1:   state_next = thp_pkg::S_P2;
            thp_pkg::S_P2:   state_next = thp_pkg::S_P3;
            thp_pkg::S_P3:   state_next = thp_pkg::S_P4;
            thp_pkg::S_P4:   state_next = thp_pkg::S_P5;
            thp_pkg::S_P5:   state_next = thp_pkg::S_P6;
            thp_pkg::S_P6:   state_next = thp_pkg::S_H0;
            thp_pkg::S_H0:   state_next = thp_pkg::S_H1;
            thp_pkg::S_H1:   state_next = thp_pkg::S_H2;
            thp_pkg::S_H2:   state_next = thp_pkg::S_H3;
            thp_pkg::S_H3:   state_next = thp_pkg::S_H4;
            thp_pkg::S_H4:   state_next = thp_pkg::S_H5;
            thp_pkg::S_H5:   state_next = thp_pkg::S_H6;
            thp_pkg::S_H6:   state_next = thp_pkg::S_H7;
            thp_pkg::S_H7:
                state_next = (den_reg == '0) ? thp_pkg::S_DONE : thp_pkg::S_WDIV;
            thp_pkg::S_WDIV: if (div_rsp.done) state_next = thp_pkg::S_Q0;
            thp_pkg::S_Q0:   state_next = thp_pkg::S_Q1;
            thp_pkg::S_Q1:   state_next = thp_pkg::S_Q2;
            thp_pkg::S_Q2:   state_next = thp_pkg::S_DONE;
            thp_pkg::S_DONE: if (out_free) state_next = thp_pkg::S_IDLE;
            default:         state_next = thp_pkg::S_IDLE;
        endcase
    end

    // Multiplier operands and handshake outputs per state.
    always_comb
    begin
        mul_a            = '0;
        mul_b            = '0;
        item_pop         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = num[31] ? num : {num[30:0], 1'b0};
        div_req.divisor  = den_reg;
        case (state_reg)
            thp_pkg::S_IDLE: item_pop = item_valid;
            thp_pkg::S_T0:
            begin
                mul_a = (adc_t_reg >> 3) - (t1 << 1);
                mul_b = t2;
            end
            thp_pkg::S_T1:
            begin
                mul_a = (adc_t_reg >> 4) - t1;
                mul_b = (adc_t_reg >> 4) - t1;
            end
            thp_pkg::S_T2:
            begin
                mul_a = rdd_reg;
                mul_b = t3;
            end
            thp_pkg::S_P0:
            begin
                mul_a = asr(pv1, 2);
                mul_b = asr(pv1, 2);
            end
            thp_pkg::S_P1:
            begin
                mul_a = asr(q_reg, 11);
                mul_b = p6;
            end
            thp_pkg::S_P2:
            begin
                mul_a = pv1_reg;
                mul_b = p5;
            end
            thp_pkg::S_P3:
            begin
                mul_a = p3;
                mul_b = asr(q_reg, 13);
            end
            thp_pkg::S_P4:
            begin
                mul_a = p2;
                mul_b = pv1_reg;
            end
            thp_pkg::S_P5:
            begin
                mul_a = thp_pkg::K_P_ONE + tmp_reg;
                mul_b = p1;
            end
            thp_pkg::S_P6:
            begin
                mul_a         = (thp_pkg::K_P_BASE - adc_p_reg) - asr(pv2_reg, 12);
                mul_b         = thp_pkg::K_P_SCALE;
                div_req.start = (den_reg != '0);
            end
            thp_pkg::S_H0:
            begin
                mul_a = h5;
                mul_b = hv1;
            end
            thp_pkg::S_H1:
            begin
                mul_a = hv1_reg;
                mul_b = h6;
            end
            thp_pkg::S_H2:
            begin
                mul_a = hv1_reg;
                mul_b = h3;
            end
            thp_pkg::S_H3:
            begin
                mul_a = ha_reg;
                mul_b = hb_reg;
            end
            thp_pkg::S_H4:
            begin
                mul_a = hd_reg;
                mul_b = h2;
            end
            thp_pkg::S_H5:
            begin
                mul_a = hq_reg;
                mul_b = hd_reg;
            end
            thp_pkg::S_H6:
            begin
                mul_a = asr(hv_reg, 15);
                mul_b = asr(hv_reg, 15);
            end
            thp_pkg::S_H7:
            begin
                mul_a = ha_reg;
                mul_b = h1;
            end
            thp_pkg::S_Q0:
            begin
                mul_a = p_reg >> 3;
                mul_b = p_reg >> 3;
            end
            thp_pkg::S_Q1:
            begin
                mul_a = p9;
                mul_b = tmp_reg;
            end
            thp_pkg::S_Q2:
            begin
                mul_a = p_reg >> 2;
                mul_b = p8;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= thp_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == thp_pkg::S_DONE && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, one multiplication result captured per step.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            thp_pkg::S_IDLE:
            begin
                adc_t_reg <= {12'b0, item.raw_temperature};
                adc_p_reg <= {12'b0, item.raw_pressure};
                adc_h_reg <= {16'b0, item.raw_humidity};
            end
            thp_pkg::S_T0: tv1_reg  <= asr(prod, 11);
            thp_pkg::S_T1: rdd_reg  <= asr(prod, 12);
            thp_pkg::S_T2: fine_reg <= tv1_reg + asr(prod, 14);
            thp_pkg::S_P0:
            begin
                pv1_reg <= pv1;
                q_reg   <= prod;
            end
            thp_pkg::S_P1: acc_reg <= prod;
            thp_pkg::S_P2: pv2_reg <= asr(acc_reg + (prod << 1), 2) + (p4 << 16);
            thp_pkg::S_P3: tmp_reg <= asr(prod, 3);
            thp_pkg::S_P4: tmp_reg <= asr(tmp_reg + asr(prod, 1), 18);
            thp_pkg::S_P5: den_reg <= asr(prod, 15);
            thp_pkg::S_P6: dbl_reg <= num[31];
            thp_pkg::S_H0:
            begin
                hv1_reg <= hv1;
                hq_reg  <= asr(((adc_h_reg << 14) - (h4 << 20) - prod)
                               + thp_pkg::K_H_ROUND, 15);
            end
            thp_pkg::S_H1: ha_reg <= asr(prod, 10);
            thp_pkg::S_H2: hb_reg <= asr(prod, 11) + thp_pkg::K_H_ONE;
            thp_pkg::S_H3: hd_reg <= asr(prod, 10) + thp_pkg::K_H_BIAS;
            thp_pkg::S_H4: hd_reg <= asr(prod + thp_pkg::K_H_ROUND2, 14);
            thp_pkg::S_H5: hv_reg <= prod;
            thp_pkg::S_H6: ha_reg <= asr(prod, 7);
            thp_pkg::S_H7:
            begin
                // Clamp to 0..419430400 before scaling down.
                if (hfin[31])
                begin
                    hum_reg <= '0;
                end
                else if (hfin > thp_pkg::K_H_MAX)
                begin
                    hum_reg <= 17'(thp_pkg::K_H_MAX >> 12);
                end
                else
                begin
                    hum_reg <= hfin[28:12];
                end
                pres_reg   <= '0;
                pvalid_reg <= 1'b0;
            end
            thp_pkg::S_WDIV:
            begin
                p_reg <= dbl_reg ? {div_rsp.quotient[30:0], 1'b0} : div_rsp.quotient;
            end
            thp_pkg::S_Q0: tmp_reg <= prod >> 13;
            thp_pkg::S_Q1: pa_reg  <= asr(prod, 12);
            thp_pkg::S_Q2:
            begin
                if (pfin[31])
                begin
                    pres_reg <= '0;
                end
                else if (pfin > thp_pkg::K_P_MAX)
                begin
                    pres_reg <= 20'hFFFFF;
                end
                else
                begin
                    pres_reg <= pfin[19:0];
                end
                pvalid_reg <= 1'b1;
            end
            thp_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    res_reg.fine_temperature  <= fine_reg;
                    res_reg.temperature_centi <= tcenti;
                    res_reg.pressure_pa       <= pres_reg;
                    res_reg.pressure_valid    <= pvalid_reg;
                    res_reg.humidity_q22_10   <= hum_reg;
                end
            end
            default:
            begin
                tmp_reg <= tmp_reg;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> sv/thp_sensor_compensation_top.sv
// Each accepted input beat passes the shared multiplier sequencer, and the divider as well
// unless the pressure divisor is zero and the division and pressure refinement are skipped.
// Sets are handled one at a time: the next set leaves the queue only once the previous
// result is in the output register; the divider runs alongside the humidity steps.
// A two-entry input queue and an output register let both sides stall independently.
// Reset (rst_n, asynchronous, active low) empties the queue and clears all trims to zero.
`default_nettype none
module thp_sensor_compensation_top #(
    parameter int FIFO_DEPTH = thp_pkg::FIFO_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // raw_temperature [19:0], raw_pressure [39:20], raw_humidity [55:40]
    input  wire logic [thp_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // fine_temperature [31:0], temperature_centi [47:32], pressure_pa [67:48],
    // humidity_q22_10 [84:68], zero fill [87:85]
    output logic [thp_pkg::OUT_DATA_W-1:0]       m_tdata,
    // pressure_valid [0]
    output logic                                 m_tuser,
    input  wire logic                            cfg_we,
    input  wire logic [thp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [thp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    thp_pkg::trim_t    trim_reg;
    thp_pkg::raw_t     item;
    logic              item_valid, item_pop;
    thp_pkg::div_req_t div_req;
    thp_pkg::div_rsp_t div_rsp;
    thp_pkg::result_t  res;

    // Trim registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                thp_pkg::CFG_TEMP_TRIM:    trim_reg.temp_trim    <= cfg_data[47:0];
                thp_pkg::CFG_PRESS_TRIM_A: trim_reg.press_trim_a <= cfg_data;
                thp_pkg::CFG_PRESS_TRIM_B: trim_reg.press_trim_b <= cfg_data;
                thp_pkg::CFG_PRESS_TRIM_C: trim_reg.press_trim_c <= cfg_data[15:0];
                thp_pkg::CFG_HUM_TRIM:     trim_reg.hum_trim     <= cfg_data;
                default:                   trim_reg              <= trim_reg;
            endcase
        end
    end

    thp_front #(.DEPTH(FIFO_DEPTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    thp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    thp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .trim       (trim_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

    // Result beat packing.
    assign m_tdata = {3'b000, res.humidity_q22_10, res.pressure_pa,
                      res.temperature_centi, res.fine_temperature};
    assign m_tuser = res.pressure_valid;
endmodule
`default_nettype wire

>>> bench/tb_thp_sensor_compensation_top.sv
// Self-checking testbench for the temperature, pressure and humidity compensation block.
`timescale 1ns / 100ps
`default_nettype none
module tb_thp_sensor_compensation_top;

    localparam int STALL_LIMIT = 20000;

    // Expected contents of one result beat.
    typedef struct {
        logic [31:0] fine;
        logic [15:0] centi;
        logic [19:0] pres;
        logic        pvalid;
        logic [16:0] hum;
    } comp_result_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [thp_pkg::IN_DATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [thp_pkg::OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we;
    logic [thp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [thp_pkg::CFG_DATA_W-1:0] cfg_data;

    // Local copy of the trimming registers.
    logic [47:0] temp_trim;
    logic [63:0] press_trim_a;
    logic [63:0] press_trim_b;
    logic [15:0] press_trim_c;
    logic [63:0] hum_trim;

    thp_pkg::raw_t raw_pending[$];
    comp_result_t  results_due[$];
    logic in_fire;
    int   cycle_count;
    int   quiet_cycles;
    int   fail_count;
    int   sets_sent;
    int   results_seen;
    int   invalid_seen;

    thp_sensor_compensation_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] sra(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] sext16(logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sext12(logic [11:0] x);
        return {{20{x[11]}}, x};
    endfunction

    // Random idling: none within a long quiet window of the run.
    function automatic bit take_pause();
        if (cycle_count > 8000 && cycle_count < 16000)
            return 1'b0;
        return ($urandom_range(0, 99) < 15);
    endfunction

    // Integer compensation of one measurement set with the current trims.
    function automatic comp_result_t compensate(thp_pkg::raw_t raw);
        comp_result_t r;
        logic [31:0] adc_t, adc_p, adc_h;
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [31:0] v1, v2, d, p, q, fine;
        longint tv;

        adc_t = {12'd0, raw.raw_temperature};
        adc_p = {12'd0, raw.raw_pressure};
        adc_h = {16'd0, raw.raw_humidity};
        t1 = {16'd0, temp_trim[15:0]};
        t2 = sext16(temp_trim[31:16]);
        t3 = sext16(temp_trim[47:32]);
        p1 = {16'd0, press_trim_a[15:0]};
        p2 = sext16(press_trim_a[31:16]);
        p3 = sext16(press_trim_a[47:32]);
        p4 = sext16(press_trim_a[63:48]);
        p5 = sext16(press_trim_b[15:0]);
        p6 = sext16(press_trim_b[31:16]);
        p7 = sext16(press_trim_b[47:32]);
        p8 = sext16(press_trim_b[63:48]);
        p9 = sext16(press_trim_c);
        h1 = {24'd0, hum_trim[7:0]};
        h2 = sext16(hum_trim[23:8]);
        h3 = {24'd0, hum_trim[31:24]};
        h4 = sext12(hum_trim[43:32]);
        h5 = sext12(hum_trim[55:44]);
        h6 = {{24{hum_trim[63]}}, hum_trim[63:56]};

        // Temperature: fine word, then rounded hundredths with saturation.
        v1 = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
        d = (adc_t >> 4) - t1;
        v2 = sra(sra(d * d, 12) * t3, 14);
        fine = v1 + v2;
        tv = longint'($signed(fine)) * 5 + 128;
        tv = tv >>> 8;
        if (tv > 32767)
            tv = 32767;
        if (tv < -32768)
            tv = -32768;
        r.fine = fine;
        r.centi = tv[15:0];

        // Pressure, with the zero divisor case flagged.
        v1 = sra(fine, 1) - thp_pkg::K_P_OFFSET;
        q = sra(v1, 2) * sra(v1, 2);
        v2 = sra(q, 11) * p6;
        v2 = v2 + ((v1 * p5) << 1);
        v2 = sra(v2, 2) + (p4 << 16);
        v1 = sra(sra(p3 * sra(q, 13), 3) + sra(p2 * v1, 1), 18);
        v1 = sra((thp_pkg::K_P_ONE + v1) * p1, 15);
        if (v1 == 32'd0)
        begin
            r.pres = '0;
            r.pvalid = 1'b0;
        end
        else
        begin
            p = ((thp_pkg::K_P_BASE - adc_p) - sra(v2, 12)) * thp_pkg::K_P_SCALE;
            if (!p[31])
                p = (p << 1) / v1;
            else
                p = (p / v1) * 32'd2;
            v1 = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            v2 = sra((p >> 2) * p8, 13);
            p = p + sra(v1 + v2 + p7, 4);
            if (p[31])
                r.pres = '0;
            else if (p > thp_pkg::K_P_MAX)
                r.pres = thp_pkg::K_P_MAX[19:0];
            else
                r.pres = p[19:0];
            r.pvalid = 1'b1;
        end

        // Humidity, clamped before the final shift.
        v1 = fine - thp_pkg::K_H_OFFSET;
        q = sra(((adc_h << 14) - (h4 << 20) - (h5 * v1)) + thp_pkg::K_H_ROUND, 15);
        d = sra(sra(v1 * h6, 10) * (sra(v1 * h3, 11) + thp_pkg::K_H_ONE), 10)
            + thp_pkg::K_H_BIAS;
        d = sra(d * h2 + thp_pkg::K_H_ROUND2, 14);
        v1 = q * d;
        v1 = v1 - sra(sra(sra(v1, 15) * sra(v1, 15), 7) * h1, 4);
        if (v1[31])
            v1 = '0;
        if (v1 > thp_pkg::K_H_MAX)
            v1 = thp_pkg::K_H_MAX;
        r.hum = v1[28:12];
        return r;
    endfunction

    // Input side: hold a beat until taken, otherwise offer the next one; m_tready is set at random.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (s_tvalid && !in_fire)
                s_tvalid <= 1'b1;
            else if (raw_pending.size() > 0 && !take_pause())
            begin
                s_tvalid <= 1'b1;
                s_tdata <= raw_pending[0];
            end
            else
                s_tvalid <= 1'b0;
            m_tready <= !take_pause();
        end
    end

    // Accepted input beats become expected results.
    always @(posedge clk)
    begin
        in_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            results_due.push_back(compensate(thp_pkg::raw_t'(s_tdata)));
            void'(raw_pending.pop_front());
            sets_sent++;
        end
    end

    // Result beats are checked field by field against the oldest expectation.
    always @(posedge clk)
    begin
        comp_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result beat, tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                e = results_due.pop_front();
                if (!e.pvalid)
                    invalid_seen++;
                if (m_tdata[31:0] !== e.fine)
                begin
                    $display("%0t: fine temperature expected %h actual %h",
                             $time, e.fine, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[47:32] !== e.centi)
                begin
                    $display("%0t: temperature expected %h actual %h",
                             $time, e.centi, m_tdata[47:32]);
                    fail_count++;
                end
                if (m_tdata[67:48] !== e.pres)
                begin
                    $display("%0t: pressure expected %h actual %h",
                             $time, e.pres, m_tdata[67:48]);
                    fail_count++;
                end
                if (m_tdata[84:68] !== e.hum)
                begin
                    $display("%0t: humidity expected %h actual %h",
                             $time, e.hum, m_tdata[84:68]);
                    fail_count++;
                end
                if (m_tuser !== e.pvalid)
                begin
                    $display("%0t: pressure flag expected %b actual %b",
                             $time, e.pvalid, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat accepted on either side.
    always @(posedge clk)
    begin
        cycle_count++;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Register write while idle; the local copy follows the same rules.
    task automatic write_trim(logic [thp_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            thp_pkg::CFG_TEMP_TRIM:    temp_trim = value[47:0];
            thp_pkg::CFG_PRESS_TRIM_A: press_trim_a = value;
            thp_pkg::CFG_PRESS_TRIM_B: press_trim_b = value;
            thp_pkg::CFG_PRESS_TRIM_C: press_trim_c = value[15:0];
            thp_pkg::CFG_HUM_TRIM:     hum_trim = value;
            default:                   ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [47:0] tt, logic [63:0] pa, logic [63:0] pb,
                             logic [15:0] pc, logic [63:0] ht);
        write_trim(thp_pkg::CFG_TEMP_TRIM, {16'd0, tt});
        write_trim(thp_pkg::CFG_PRESS_TRIM_A, pa);
        write_trim(thp_pkg::CFG_PRESS_TRIM_B, pb);
        write_trim(thp_pkg::CFG_PRESS_TRIM_C, {48'd0, pc});
        write_trim(thp_pkg::CFG_HUM_TRIM, ht);
    endtask

    task automatic queue_set(logic [19:0] t, logic [19:0] p, logic [15:0] h);
        thp_pkg::raw_t r;
        r.raw_temperature = t;
        r.raw_pressure = p;
        r.raw_humidity = h;
        raw_pending.push_back(r);
    endtask

    // Half full-range readings, half around plausible room conditions.
    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 1))
                queue_set(20'($urandom()), 20'($urandom()), 16'($urandom()));
            else
                queue_set(20'($urandom_range(440000, 600000)),
                          20'($urandom_range(250000, 550000)),
                          16'($urandom_range(15000, 45000)));
        end
    endtask

    // Let every queued set come back, then allow for the block's latency.
    task automatic drain();
        while (raw_pending.size() > 0 || results_due.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Typical trims of a production part.
    localparam logic [47:0] TT_TYP = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] PA_TYP = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] PB_TYP = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [15:0] PC_TYP = 16'd6000;
    localparam logic [63:0] HT_TYP = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_fire = 1'b0;
        cycle_count = 0;
        quiet_cycles = 0;
        fail_count = 0;
        sets_sent = 0;
        results_seen = 0;
        invalid_seen = 0;
        temp_trim = '0;
        press_trim_a = '0;
        press_trim_b = '0;
        press_trim_c = '0;
        hum_trim = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset trims: the pressure divisor is zero.
        queue_set(20'd0, 20'd0, 16'd0);
        queue_set(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        queue_random(200);
        drain();

        // Typical trims with directed corners; unknown indexes must be ignored.
        write_all(TT_TYP, PA_TYP, PB_TYP, PC_TYP, HT_TYP);
        write_trim(3'd5, 64'hFFFF_FFFF_FFFF_FFFF);
        write_trim(3'd6, 64'h1234_5678_9ABC_DEF0);
        write_trim(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_set(20'd519888, 20'd415148, 16'd30000);
        queue_set(20'd0, 20'd0, 16'd0);
        queue_set(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        queue_set(20'd0, 20'hFFFFF, 16'hFFFF);
        queue_set(20'hFFFFF, 20'd0, 16'd0);
        queue_set(20'd519888, 20'd0, 16'd0);
        queue_set(20'd519888, 20'hFFFFF, 16'hFFFF);
        queue_set(20'd519888, 20'd100, 16'd65000);
        queue_set(20'd440064, 20'd415148, 16'd8000);
        queue_set(20'd600000, 20'd415148, 16'd50000);
        queue_set(20'hAAAAA, 20'h55555, 16'hAAAA);
        queue_set(20'h55555, 20'hAAAAA, 16'h5555);
        queue_random(200);
        drain();

        // Register extremes: all ones, largest positive, most negative.
        write_all('1, '1, '1, '1, '1);
        queue_random(200);
        drain();
        write_all({3{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF, {8{8'h7F}});
        queue_random(200);
        drain();
        write_all({3{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 16'h8000, {8{8'h80}});
        queue_random(200);
        drain();

        // Zero P1 with otherwise typical trims.
        write_all(TT_TYP, {PA_TYP[63:16], 16'd0}, PB_TYP, PC_TYP, HT_TYP);
        queue_random(150);
        drain();

        // Random trims, some near typical values.
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph[0])
                write_all(48'({$urandom(), $urandom()}), {$urandom(), $urandom()},
                          {$urandom(), $urandom()}, 16'($urandom()),
                          {$urandom(), $urandom()});
            else
                write_all(TT_TYP ^ 48'({$urandom_range(0, 255), $urandom_range(0, 255)}),
                          PA_TYP ^ {$urandom_range(0, 255), $urandom_range(0, 255)},
                          PB_TYP ^ {$urandom_range(0, 255), $urandom_range(0, 255)},
                          PC_TYP ^ 16'($urandom_range(0, 255)),
                          HT_TYP ^ {$urandom_range(0, 255), $urandom_range(0, 255)});
            queue_random(200);
            drain();
        end

        $display("Compensated %0d measurement sets over ten trim settings;", sets_sent);
        $display("%0d results checked, %0d with the pressure divisor at zero.",
                 results_seen, invalid_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
sv/thp_pkg.sv
sv/thp_front.sv
sv/thp_div.sv
sv/thp_back.sv
sv/thp_sensor_compensation_top.sv
bench/tb_thp_sensor_compensation_top.sv
